### src/midi_to_usb_midi_packetizer_defines.svh
// assertion macros shared by the packetizer modules
// they expect clk_i and rst_ni in the enclosing scope
`ifndef MIDI_TO_USB_MIDI_PACKETIZER_DEFINES_SVH
`define MIDI_TO_USB_MIDI_PACKETIZER_DEFINES_SVH

// property must hold at every clock edge out of reset
`define M2U_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// when trig holds, prop must hold at the following clock edge
`define M2U_ASSERT_NEXT(name, trig, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error(msg);

`endif

### src/m2u_pkg.sv
`default_nettype none

package m2u_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // status bytes
  localparam logic [7:0] StSysexStart = 8'hF0;
  localparam logic [7:0] StTimeCode   = 8'hF1;
  localparam logic [7:0] StSongPos    = 8'hF2;
  localparam logic [7:0] StSongSel    = 8'hF3;
  localparam logic [7:0] StTune       = 8'hF6;
  localparam logic [7:0] StSysexEnd   = 8'hF7;

  // code index numbers
  localparam logic [3:0] CinSysCom2   = 4'h2;
  localparam logic [3:0] CinSysCom3   = 4'h3;
  localparam logic [3:0] CinSingle    = 4'h5;
  localparam logic [3:0] CinRealTime  = 4'hF;

  // two-byte channel messages by status high nibble (low three bits)
  localparam logic [7:0] ChanTwo = 8'b0011_0000;

  typedef enum logic [2:0] {
    K_REALTIME    = 3'd0,
    K_SYSEX_START = 3'd1,
    K_SYSEX_END   = 3'd2,
    K_CLEAR       = 3'd3,
    K_TUNE        = 3'd4,
    K_SYSCOM      = 3'd5,
    K_CHAN        = 3'd6,
    K_DATA        = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  value;
    logic        two;
    logic [3:0]  cin;
  } item_t;

  function automatic logic chan_two(input logic [7:0] st);
    return ChanTwo[st[6:4]];
  endfunction

endpackage

`default_nettype wire

### src/m2u_front.sv
`default_nettype none

module m2u_front (
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    midi_byte_i,
  input  wire logic          q_full_i,
  output logic               push_o,
  output m2u_pkg::item_t     item_o
);
  import m2u_pkg::*;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    item_o.value = midi_byte_i;
    item_o.two   = 1'b0;
    item_o.cin   = CinRealTime;
    item_o.kind  = K_CLEAR;
    if (midi_byte_i[7:3] == 5'b11111) begin
      item_o.kind = K_REALTIME;
    end else if (!midi_byte_i[7]) begin
      item_o.kind = K_DATA;
    end else if (midi_byte_i[7:4] != 4'hF) begin
      item_o.kind = K_CHAN;
      item_o.two  = chan_two(midi_byte_i);
      item_o.cin  = midi_byte_i[7:4];
    end else begin
      priority case (midi_byte_i)
        StSysexStart: item_o.kind = K_SYSEX_START;
        StSysexEnd:   item_o.kind = K_SYSEX_END;
        StTune: begin
          item_o.kind = K_TUNE;
          item_o.cin  = CinSingle;
        end
        StTimeCode, StSongSel: begin
          item_o.kind = K_SYSCOM;
          item_o.two  = 1'b1;
          item_o.cin  = CinSysCom2;
        end
        StSongPos: begin
          item_o.kind = K_SYSCOM;
          item_o.cin  = CinSysCom3;
        end
        default: item_o.kind = K_CLEAR;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/m2u_queue.sv
`default_nettype none
`include "midi_to_usb_midi_packetizer_defines.svh"

module m2u_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire m2u_pkg::item_t item_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire logic           pop_i,
  output m2u_pkg::item_t      item_o
);
  import m2u_pkg::*;

  item_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  `M2U_ASSERT(a_no_overflow, !(push_i && full_o && !pop_i), "push into full queue")
  `M2U_ASSERT(a_no_underflow, !(pop_i && !valid_o), "pop from empty queue")

endmodule

`default_nettype wire

### src/m2u_back.sv
`default_nettype none
`include "midi_to_usb_midi_packetizer_defines.svh"

module m2u_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_valid_i,
  input  wire m2u_pkg::item_t item_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [3:0]          code_index_o,
  output logic [7:0]          msg_status_o,
  output logic [7:0]          msg_data1_o,
  output logic [7:0]          msg_data2_o
);
  import m2u_pkg::*;

  typedef enum logic [2:0] {
    HELD_NONE   = 3'b001,
    HELD_STATUS = 3'b010,
    HELD_DATA   = 3'b100
  } held_e;

  held_e       held_q, held_d;
  logic        in_sysex_q, in_sysex_d;
  logic        run_valid_q, run_valid_d;
  logic [7:0]  run_status_q, run_status_d;
  logic [7:0]  held_status_q, held_status_d;
  logic        held_two_q, held_two_d;
  logic [3:0]  held_cin_q, held_cin_d;
  logic [7:0]  held_data1_q, held_data1_d;

  logic        out_valid_q, out_valid_d;
  logic [3:0]  cin_q, cin_d;
  logic [7:0]  st_q, st_d;
  logic [7:0]  d1_q, d1_d;
  logic [7:0]  d2_q, d2_d;

  logic        emit;
  logic [7:0]  eff_status;
  logic        eff_two;
  logic [3:0]  eff_cin;

  assign pop_o        = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign code_index_o = cin_q;
  assign msg_status_o = st_q;
  assign msg_data1_o  = d1_q;
  assign msg_data2_o  = d2_q;

  // running status stands in when nothing is held
  always_comb begin
    if (held_q == HELD_NONE) begin
      eff_status = run_status_q;
      eff_two    = chan_two(run_status_q);
      eff_cin    = run_status_q[7:4];
    end else begin
      eff_status = held_status_q;
      eff_two    = held_two_q;
      eff_cin    = held_cin_q;
    end
  end

  always_comb begin
    held_d        = held_q;
    in_sysex_d    = in_sysex_q;
    run_valid_d   = run_valid_q;
    run_status_d  = run_status_q;
    held_status_d = held_status_q;
    held_two_d    = held_two_q;
    held_cin_d    = held_cin_q;
    held_data1_d  = held_data1_q;
    emit          = 1'b0;
    cin_d         = item_i.cin;
    st_d          = item_i.value;
    d1_d          = '0;
    d2_d          = '0;

    if (pop_o) begin
      if (item_i.kind == K_REALTIME) begin
        emit = 1'b1;
      end else if (in_sysex_q) begin
        if (item_i.kind == K_SYSEX_END) begin
          in_sysex_d = 1'b0;
        end
      end else begin
        unique case (item_i.kind)
          K_CHAN: begin
            run_status_d  = item_i.value;
            run_valid_d   = 1'b1;
            held_status_d = item_i.value;
            held_two_d    = item_i.two;
            held_cin_d    = item_i.cin;
            held_d        = HELD_STATUS;
          end
          K_SYSCOM: begin
            run_valid_d   = 1'b0;
            held_status_d = item_i.value;
            held_two_d    = item_i.two;
            held_cin_d    = item_i.cin;
            held_d        = HELD_STATUS;
          end
          K_SYSEX_START: begin
            in_sysex_d  = 1'b1;
            run_valid_d = 1'b0;
            held_d      = HELD_NONE;
          end
          K_TUNE: begin
            run_valid_d = 1'b0;
            held_d      = HELD_NONE;
            emit        = 1'b1;
          end
          K_DATA: begin
            if (held_q == HELD_DATA) begin
              emit   = 1'b1;
              cin_d  = held_cin_q;
              st_d   = held_status_q;
              d1_d   = held_data1_q;
              d2_d   = item_i.value;
              held_d = HELD_NONE;
            end else if (held_q != HELD_NONE || run_valid_q) begin
              held_status_d = eff_status;
              held_two_d    = eff_two;
              held_cin_d    = eff_cin;
              if (eff_two) begin
                emit   = 1'b1;
                cin_d  = eff_cin;
                st_d   = eff_status;
                d1_d   = item_i.value;
                held_d = HELD_NONE;
              end else begin
                held_data1_d = item_i.value;
                held_d       = HELD_DATA;
              end
            end
          end
          K_SYSEX_END, K_CLEAR, K_REALTIME: begin
            run_valid_d = 1'b0;
            held_d      = HELD_NONE;
          end
          default: begin
            run_valid_d = 1'b0;
            held_d      = HELD_NONE;
          end
        endcase
      end
    end

    if (pop_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q       <= HELD_NONE;
      in_sysex_q   <= 1'b0;
      run_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      run_status_q <= '0;
    end else begin
      held_q       <= held_d;
      in_sysex_q   <= in_sysex_d;
      run_valid_q  <= run_valid_d;
      out_valid_q  <= out_valid_d;
      run_status_q <= run_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_status_q <= held_status_d;
    held_two_q    <= held_two_d;
    held_cin_q    <= held_cin_d;
    held_data1_q  <= held_data1_d;
    if (pop_o && emit) begin
      cin_q <= cin_d;
      st_q  <= st_d;
      d1_q  <= d1_d;
      d2_q  <= d2_d;
    end
  end

  `M2U_ASSERT(a_sysex_clean, !in_sysex_q || (held_q == HELD_NONE && !run_valid_q), "sysex with live message state")
  `M2U_ASSERT_NEXT(a_rt_out, pop_o && item_i.kind == K_REALTIME, out_valid_q && cin_q == CinRealTime, "real-time byte not emitted")

endmodule

`default_nettype wire

### src/midi_to_usb_midi_packetizer.sv
// channel  dir  signals
// in       in   in_valid_i, in_ready_o, midi_byte_i
// out      out  out_valid_o, out_ready_i, code_index_o, msg_status_o,
//               msg_data1_o, msg_data2_o
//
// one byte per cycle if output not stalled; bytes pass queue, then output regs
// the back end updates message state for one queued byte each unstalled cycle
// a two-entry queue splits byte intake from packet assembly
// reset clears running status, held message, sysex mode and both valids
// a stalled output stops the back end; intake stops once the queue fills
`default_nettype none

module midi_to_usb_midi_packetizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  midi_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       code_index_o,
  output logic [7:0]       msg_status_o,
  output logic [7:0]       msg_data1_o,
  output logic [7:0]       msg_data2_o
);
  import m2u_pkg::*;

  item_t  front_item;
  item_t  q_item;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_valid;

  m2u_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .midi_byte_i (midi_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  m2u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .item_o  (q_item)
  );

  m2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .item_i       (q_item),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_index_o (code_index_o),
    .msg_status_o (msg_status_o),
    .msg_data1_o  (msg_data1_o),
    .msg_data2_o  (msg_data2_o)
  );

endmodule

`default_nettype wire
